@@ sv/q_learning_method_selector_defines.svh @@
// assertion macros for the q-learning method selector
// used by q_learning_method_selector.sv; no other dependencies
`ifndef Q_LEARNING_METHOD_SELECTOR_DEFINES_SVH
`define Q_LEARNING_METHOD_SELECTOR_DEFINES_SVH

// checked property on clk, held off while rst_n is low
`define QLMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property on clk, also during reset
`define QLMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/qlms_pkg.sv @@
// constants, types and helpers for the q-learning method selector
// no dependencies; imported by q_learning_method_selector
package qlms_pkg;

  localparam int NUM_STATES    = 12;
  localparam int NUM_METHODS   = 12;
  localparam int EXPLORE_STEPS = 144;

  // table geometry
  localparam int Q_DEPTH = NUM_STATES * NUM_METHODS;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int CNT_W   = Q_AW + 1;

  // explore-phase timestep width and reciprocal for mod NUM_METHODS
  localparam int TS_W     = $clog2(EXPLORE_STEPS + 1);
  localparam int RECIP_SH = 16;
  localparam int RECIP    = (1 << RECIP_SH) / NUM_METHODS;

  // register indexes
  localparam logic CFG_LEARN_RATE = 1'b0;
  localparam logic CFG_DISCOUNT   = 1'b1;

  localparam logic [15:0] LEARN_RATE_RST = 16'd3277;
  localparam logic [15:0] DISCOUNT_RST   = 16'd29491;

  localparam logic signed [15:0] Q_RST       = -16'sd19136;
  localparam logic signed [15:0] Q_MIN       = -16'sd32768;
  localparam logic signed [31:0] LOW_MARK_RST  = -32'sd99;
  localparam logic signed [31:0] HIGH_MARK_RST = -32'sd999;

  // reward codes
  localparam logic signed [2:0] REW_POS  = 3'sd2;
  localparam logic signed [2:0] REW_ZERO = 3'sd0;
  localparam logic signed [2:0] REW_NEG  = -3'sd2;

  typedef logic [3:0]        idx_t;
  typedef logic [Q_AW-1:0]   qaddr_t;
  typedef logic signed [15:0] qval_t;

  // clamp a state to the last row
  function automatic idx_t row_of(input idx_t s);
    row_of = ({1'b0, s} >= 5'(NUM_STATES)) ? idx_t'(NUM_STATES - 1) : s;
  endfunction

endpackage

@@ sv/q_learning_method_selector.sv @@
// q-learning method selector: top level with table memory and sequencer
// depends on qlms_pkg and q_learning_method_selector_defines.svh
//
// Usage
//   Input channel in_*: func 0 asks for a method for in_timestep, func 1
//   reports in_exec_time for in_taken_method. Each item gives one result on
//   out_*: out_method for select items, out_reward_given for reward items.
//   The user must give config writes (cfg_we, cfg_index, cfg_wdata) only
//   while the block idles; the block leaves enforcing this to the user.
// Throughput and scans
//   One item at a time. Greedy select scans a row of the table memory.
//   Reward: the full-table maximum search reads the single read port once
//   per cycle.
// Reset
//   rst_n synchronous, active low. All table entries read as -299.0 via
//   per-entry valid flags; marks, states and registers return to defaults.
// Back-pressure
//   A finished result waits in the output register while out_stall is
//   high; a following item is taken and worked on, and its result waits
//   in the sequencer until the output register frees.
module q_learning_method_selector (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [31:0]          in_timestep,
  input  logic [30:0]          in_exec_time,
  input  logic [3:0]           in_taken_method,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_method,
  output logic signed [2:0]    out_reward_given,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import qlms_pkg::*;
  `include "q_learning_method_selector_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_SEL_MUL, S_SEL_REM, S_REW_QV, S_SCAN, S_MUL1, S_MUL2, S_WR, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0] learn_rate_r, discount_r;

  // agent state
  idx_t cur_r, trial_r;
  logic signed [31:0] low_mark_r, high_mark_r;

  // item context
  logic              is_rew_r;
  idx_t              row_r, act_r;
  logic              act_ok_r;
  logic signed [2:0] rew_r;
  logic [TS_W-1:0]   ts_lo_r;
  logic [TS_W-1:0]   quo_r;
  qval_t             qval_r;

  // scan control
  qaddr_t            base_r;
  logic [CNT_W-1:0]  len_r, k_r;
  idx_t              col_r, pcol_r, bcol_r;
  logic              p_r;
  qval_t             best_r;

  // update arithmetic
  logic signed [34:0] t_r;
  logic signed [51:0] prod_r;

  // pending result
  idx_t              res_m_r;
  logic signed [2:0] res_rew_r;

  // output register
  logic              out_valid_r;
  idx_t              out_m_r;
  logic signed [2:0] out_rew_r;

  // table memory with per-entry valid flags
  qval_t  mem [Q_DEPTH];
  logic [Q_DEPTH-1:0] vld_r;
  logic   rd_en, we;
  qaddr_t rd_addr, wr_addr;
  qval_t  wr_data, rdata_r, q_rd;
  logic   rvld_r;

  logic in_xfer, out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_method       = out_m_r;
  assign out_reward_given = out_rew_r;

  // reward classification from the marks
  logic signed [32:0] et_s, low_s, high_s, low1_s;
  logic signed [31:0] low_nxt, high_nxt;
  logic signed [2:0]  rew_nxt;
  always_comb begin
    et_s   = {2'b00, in_exec_time};
    low_s  = {low_mark_r[31], low_mark_r};
    high_s = {high_mark_r[31], high_mark_r};
    low_nxt  = low_mark_r;
    high_nxt = high_mark_r;
    rew_nxt  = REW_ZERO;
    if (et_s < low_s) begin
      low_nxt = {1'b0, in_exec_time};
      rew_nxt = REW_POS;
    end
    low1_s = {low_nxt[31], low_nxt};
    if (et_s > low1_s && et_s < high_s) begin
      low_nxt = {1'b0, in_exec_time};
      rew_nxt = REW_ZERO;
    end
    if (et_s > high_s) begin
      high_nxt = {1'b0, in_exec_time};
      rew_nxt  = REW_NEG;
    end
  end

  idx_t   in_row;
  qaddr_t in_base;
  assign in_row  = row_of(cur_r);
  assign in_base = qaddr_t'(32'(in_row) * NUM_METHODS);

  // read port select; the reward scan covers the whole table from entry 0
  logic scan_issue;
  assign scan_issue = (state_r == S_SCAN) && (k_r != len_r);
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = (is_rew_r ? '0 : base_r) + k_r[Q_AW-1:0];
    if (state_r == S_IDLE) begin
      rd_en   = in_xfer && in_func;
      rd_addr = in_base + qaddr_t'(in_taken_method);
    end else if (scan_issue) begin
      rd_en = 1'b1;
    end
  end
  assign q_rd = rvld_r ? rdata_r : Q_RST;

  // memory read and write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
      if (we) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // explore-phase remainder
  logic [TS_W:0]   rem_full;
  idx_t            rem;
  logic [TS_W+RECIP_SH:0] quo_prod;
  assign quo_prod = (TS_W+RECIP_SH+1)'(ts_lo_r) * (TS_W+RECIP_SH+1)'(RECIP);
  always_comb begin
    rem_full = (TS_W+1)'(ts_lo_r) - (TS_W+1)'(32'(quo_r) * NUM_METHODS);
    if (rem_full >= (TS_W+1)'(NUM_METHODS)) begin
      rem_full = rem_full - (TS_W+1)'(NUM_METHODS);
    end
    rem = idx_t'(rem_full);
  end

  // update result with rounding and saturation
  logic signed [21:0] d;
  logic signed [23:0] nv;
  logic signed [51:0] prod_rnd;
  assign prod_rnd = prod_r + 52'sd536870912;
  assign d  = prod_rnd[51:30];
  assign nv = 24'(qval_r) + 24'(d);
  always_comb begin
    wr_addr = base_r + qaddr_t'(act_r);
    we      = (state_r == S_WR) && act_ok_r;
    if (nv > 24'sd32767) begin
      wr_data = 16'sd32767;
    end else if (nv < -24'sd32768) begin
      wr_data = Q_MIN;
    end else begin
      wr_data = nv[15:0];
    end
  end

  // sequencer, agent state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      learn_rate_r <= LEARN_RATE_RST;
      discount_r   <= DISCOUNT_RST;
      cur_r        <= '0;
      trial_r      <= '0;
      low_mark_r   <= LOW_MARK_RST;
      high_mark_r  <= HIGH_MARK_RST;
      out_valid_r  <= 1'b0;
      p_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LEARN_RATE) begin
          learn_rate_r <= cfg_wdata;
        end else begin
          discount_r <= cfg_wdata;
        end
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      p_r <= scan_issue;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_func) begin
              low_mark_r  <= low_nxt;
              high_mark_r <= high_nxt;
              state_r     <= S_REW_QV;
            end else if (in_timestep < 32'(EXPLORE_STEPS)) begin
              state_r <= S_SEL_MUL;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SEL_MUL: state_r <= S_SEL_REM;
        S_SEL_REM: begin
          if (rem == '0) begin
            if (ts_lo_r == '0 || trial_r == idx_t'(NUM_STATES - 1)) begin
              trial_r <= '0;
              cur_r   <= '0;
            end else begin
              trial_r <= trial_r + idx_t'(1);
              cur_r   <= trial_r + idx_t'(1);
            end
          end else begin
            cur_r <= trial_r;
          end
          state_r <= S_DONE;
        end
        S_REW_QV: state_r <= S_SCAN;
        S_SCAN: begin
          if (k_r == len_r && !p_r) begin
            if (is_rew_r) begin
              cur_r   <= bcol_r;
              state_r <= S_MUL1;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_WR;
        S_WR:   state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_m_r   <= res_m_r;
      out_rew_r <= res_rew_r;
    end
    case (state_r)
      S_IDLE: begin
        is_rew_r <= in_func;
        row_r    <= in_row;
        act_r    <= in_taken_method;
        act_ok_r <= ({1'b0, in_taken_method} < 5'(NUM_METHODS));
        rew_r    <= rew_nxt;
        ts_lo_r  <= in_timestep[TS_W-1:0];
        k_r      <= '0;
        col_r    <= '0;
        best_r   <= Q_MIN;
        bcol_r   <= '0;
        if (in_func) begin
          base_r <= '0;
          len_r  <= CNT_W'(Q_DEPTH);
        end else begin
          base_r <= in_base;
          len_r  <= CNT_W'(NUM_METHODS);
        end
      end
      S_SEL_MUL: quo_r <= TS_W'(quo_prod >> RECIP_SH);
      S_SEL_REM: begin
        res_m_r   <= rem;
        res_rew_r <= REW_ZERO;
      end
      S_REW_QV: begin
        qval_r <= q_rd;
        base_r <= qaddr_t'(32'(row_r) * NUM_METHODS);
      end
      S_SCAN: begin
        if (scan_issue) begin
          k_r    <= k_r + CNT_W'(1);
          pcol_r <= col_r;
          col_r  <= (col_r == idx_t'(NUM_METHODS - 1)) ? '0 : col_r + idx_t'(1);
        end
        if (p_r && q_rd > best_r) begin
          best_r <= q_rd;
          bcol_r <= pcol_r;
        end
        if (k_r == len_r && !p_r) begin
          res_m_r   <= is_rew_r ? '0 : bcol_r;
          res_rew_r <= is_rew_r ? rew_r : REW_ZERO;
        end
      end
      S_MUL1: begin
        t_r <= (35'(rew_r) <<< 21)
             + 35'($signed({1'b0, discount_r}) * best_r)
             - (35'(qval_r) <<< 15);
      end
      S_MUL2: prod_r <= 52'($signed({1'b0, learn_rate_r}) * t_r);
      default: ;
    endcase
  end

  // checks
  `QLMS_ASSERT(a_busy_after_xfer, in_xfer |=> (state_r != S_IDLE), "idle after a transfer")
  `QLMS_ASSERT(a_one_field_zero, out_valid |-> (out_method == '0 || out_reward_given == '0),
    "both result fields non-zero")
  `QLMS_ASSERT(a_reward_code, out_valid |-> (out_reward_given == REW_POS ||
    out_reward_given == REW_ZERO || out_reward_given == REW_NEG), "bad reward code")
  `QLMS_ASSERT_ALWAYS(a_cur_in_range, !rst_n || ({1'b0, cur_r} < 5'(NUM_METHODS)),
    "current state out of range")

endmodule
